[rtl/core/assert_macros.svh]
// Assertion macros shared by the RTL of the sensor alarm rule evaluator.
// Depends on nothing; a file that asserts includes it and names clk_i/rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Checked on every rising edge outside reset.
`define ASSERT_SYNC(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`else

`define ASSERT_SYNC(lbl, prop, msg)
`define ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

[rtl/core/sare_pkg.sv]
// Types and constants of the sensor alarm rule evaluator.
// No dependencies; imported by sare_rule_eval and sensor_alarm_rule_evaluator.
package sare_pkg;

  localparam int unsigned RULE_SLOTS = 16;
  localparam int unsigned SLOT_W     = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
  localparam int unsigned CNT_W      = $clog2(RULE_SLOTS + 1);

  localparam int unsigned MS_PER_S   = 1000;
  localparam int unsigned HOLD_W     = 16;
  localparam int unsigned HOLD_MS_W  = 26;  // 65535 s * 1000 fits
  localparam int unsigned HOLD_RST_S = 60;

  localparam int unsigned IN_DATA_W  = 176;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 40;

  localparam logic [1:0] MODE_THR   = 2'd0;
  localparam logic [1:0] MODE_STATE = 2'd1;
  localparam logic [1:0] MODE_COUNT = 2'd2;
  localparam logic [1:0] MODE_TICK  = 2'd3;

  localparam logic [1:0] SIDE_NONE = 2'd0;
  localparam logic [1:0] SIDE_LO   = 2'd1;
  localparam logic [1:0] SIDE_HI   = 2'd2;

  localparam logic EDGE_ACT   = 1'b0;
  localparam logic EDGE_DEACT = 1'b1;

  typedef struct packed {
    logic [1:0]         mode;
    logic [3:0]         source;
    logic [3:0]         quantity;
    logic               enabled;
    logic signed [31:0] low_limit;
    logic signed [31:0] high_limit;
    logic [30:0]        hysteresis;
    logic               reading_valid;
    logic signed [31:0] reading;
    logic               from_level;
    logic               to_level;
    logic [31:0]        now_ms;
  } item_t;

  // Per-slot state as held in the slot memory.
  typedef struct packed {
    logic        active;
    logic [1:0]  side;
    logic        lvl_valid;
    logic        lvl_val;
    logic        cnt_valid;
    logic [31:0] cnt_val;
    logic        exp_pending;
    logic [31:0] exp_time;
  } slot_rec_t;

  // Threshold bounds and expiry time, registered in the cycle before evaluation.
  typedef struct packed {
    logic signed [33:0] lo_plus;
    logic signed [33:0] lo_minus;
    logic signed [33:0] hi_plus;
    logic signed [33:0] hi_minus;
    logic [31:0]        exp_time;
  } bounds_t;

  // Packed so that event_valid lands in bit 0 of the output tdata.
  typedef struct packed {
    logic               no_free_slot;
    logic               any_active;
    logic               rule_active;
    logic signed [31:0] report_value;
    logic               has_value;
    logic [1:0]         side;
    logic               edge_res;
    logic               event_valid;
  } res_t;

endpackage

[rtl/core/sare_rule_eval.sv]
// Evaluation of one rule against the state record of its slot.
// Depends on sare_pkg; instantiated by sensor_alarm_rule_evaluator.
module sare_rule_eval import sare_pkg::*; (
  input  item_t     item_i,
  input  bounds_t   bnd_i,
  input  slot_rec_t rec_i,
  output slot_rec_t rec_o,
  output res_t      res_o
);

  logic signed [33:0] val_w;
  logic               cur;
  logic               want;
  logic [31:0]        delta;
  logic               lim_pos;

  assign val_w   = {{2{item_i.reading[31]}}, item_i.reading};
  assign cur     = |item_i.reading;
  assign want    = (cur == item_i.to_level);
  assign delta   = item_i.reading - rec_i.cnt_val;
  assign lim_pos = !item_i.high_limit[31] && (item_i.high_limit != '0);

  always_comb begin
    rec_o = rec_i;
    res_o = '0;
    unique case (item_i.mode)
      MODE_THR: begin
        if (!item_i.enabled || !item_i.reading_valid) begin
          if (rec_i.active) begin
            rec_o.active      = 1'b0;
            res_o.event_valid = 1'b1;
            res_o.edge_res    = EDGE_DEACT;
            res_o.side        = rec_i.side;
          end
        end else if (rec_i.active) begin
          if (val_w > bnd_i.lo_plus && val_w < bnd_i.hi_minus) begin
            rec_o.active       = 1'b0;
            res_o.event_valid  = 1'b1;
            res_o.edge_res     = EDGE_DEACT;
            res_o.side         = rec_i.side;
            res_o.has_value    = 1'b1;
            res_o.report_value = item_i.reading;
          end
        end else if (val_w < bnd_i.lo_minus) begin
          rec_o.active       = 1'b1;
          rec_o.side         = SIDE_LO;
          res_o.event_valid  = 1'b1;
          res_o.edge_res     = EDGE_ACT;
          res_o.side         = SIDE_LO;
          res_o.has_value    = 1'b1;
          res_o.report_value = item_i.reading;
        end else if (val_w > bnd_i.hi_plus) begin
          rec_o.active       = 1'b1;
          rec_o.side         = SIDE_HI;
          res_o.event_valid  = 1'b1;
          res_o.edge_res     = EDGE_ACT;
          res_o.side         = SIDE_HI;
          res_o.has_value    = 1'b1;
          res_o.report_value = item_i.reading;
        end
      end
      MODE_STATE: begin
        if (item_i.reading_valid) begin
          if (!item_i.enabled) begin
            if (rec_i.active) begin
              rec_o.active      = 1'b0;
              rec_o.exp_pending = 1'b0;
              rec_o.exp_time    = '0;
              res_o.event_valid = 1'b1;
              res_o.edge_res    = EDGE_DEACT;
              res_o.has_value   = 1'b1;
            end
          end else if (item_i.from_level != item_i.to_level) begin
            // edge rule: one-shot, cleared later by a tick
            if (rec_i.lvl_valid && rec_i.lvl_val == item_i.from_level && want) begin
              rec_o.active       = 1'b1;
              rec_o.exp_pending  = 1'b1;
              rec_o.exp_time     = bnd_i.exp_time;
              res_o.event_valid  = 1'b1;
              res_o.edge_res     = EDGE_ACT;
              res_o.has_value    = 1'b1;
              res_o.report_value = {31'd0, cur};
            end
          end else if (want && !rec_i.active) begin
            rec_o.active       = 1'b1;
            res_o.event_valid  = 1'b1;
            res_o.edge_res     = EDGE_ACT;
            res_o.has_value    = 1'b1;
            res_o.report_value = {31'd0, cur};
          end else if (!want && rec_i.active) begin
            rec_o.active       = 1'b0;
            res_o.event_valid  = 1'b1;
            res_o.edge_res     = EDGE_DEACT;
            res_o.has_value    = 1'b1;
            res_o.report_value = {31'd0, cur};
          end
          rec_o.lvl_valid = 1'b1;
          rec_o.lvl_val   = cur;
        end
      end
      MODE_COUNT: begin
        if (item_i.reading_valid) begin
          if (!rec_i.cnt_valid) begin
            rec_o.cnt_valid = 1'b1;
            rec_o.cnt_val   = item_i.reading;
          end else if (!item_i.enabled) begin
            rec_o.cnt_val = item_i.reading;
          end else if (lim_pos && delta >= item_i.high_limit) begin
            rec_o.active       = 1'b1;
            rec_o.exp_pending  = 1'b1;
            rec_o.exp_time     = bnd_i.exp_time;
            rec_o.cnt_val      = item_i.reading;
            res_o.event_valid  = 1'b1;
            res_o.edge_res     = EDGE_ACT;
            res_o.has_value    = 1'b1;
            res_o.report_value = item_i.reading;
          end
        end
      end
      default: begin
        // ticks are handled by the slot sweep
      end
    endcase
    res_o.rule_active = rec_o.active;
  end

endmodule

[rtl/core/sensor_alarm_rule_evaluator.sv]
// Sensor alarm rule evaluator: slot lookup, slot memory and tick sweep.
// Depends on sare_pkg, sare_rule_eval and assert_macros.svh.
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid/s_axis_tready    tdata: rule and reading, tuser: mode
//  m_axis    out  m_axis_tvalid/m_axis_tready    tdata: alarm result
//  cfg       in   cfg_valid_i/cfg_ready_o        cfg_data_i: notif_hold_s
//
// A rule item passes through accept, key match and slot read, then evaluate and write back.
// A tick sweeps the slot memory, one slot read per cycle with the write back behind it.
// The slot memory has one read and one write port. Reset clears the slot used bits
// only; a claimed slot starts from a cleared record. A result waits in the output register
// while the next item is accepted; a stalled output holds the block in its last stage.
module sensor_alarm_rule_evaluator import sare_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // source, quantity, enabled, low_limit, high_limit, hysteresis,
  // reading_valid, reading, from_level, to_level, now_ms, zero fill
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // mode
  input  logic [IN_USER_W-1:0]  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // event_valid, edge_res, side, has_value, report_value, rule_active,
  // any_active, no_free_slot
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [HOLD_W-1:0]     cfg_data_i
);

`include "assert_macros.svh"

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_FIND = 3'd1;
  localparam logic [2:0] S_EVAL = 3'd2;
  localparam logic [2:0] S_TICK = 3'd3;
  localparam logic [2:0] S_TRES = 3'd4;

  logic [2:0] state_q, state_d;

  item_t item_q, item_in;
  logic  in_xfer;

  logic [HOLD_MS_W-1:0] hold_ms_q;

  logic [RULE_SLOTS-1:0] slot_used_q;
  logic [7:0]            slot_key_q [RULE_SLOTS];
  logic [RULE_SLOTS-1:0] hit_vec;
  logic                  hit_any, free_any;
  logic [SLOT_W-1:0]     hit_idx, free_idx;
  logic [7:0]            key;

  logic [SLOT_W-1:0] slot_q;
  logic              claim_q, full_q;
  bounds_t           bnd_q, bnd_d;

  slot_rec_t         slot_mem_q [RULE_SLOTS];
  slot_rec_t         rd_data_q;
  logic              mem_re, mem_we;
  logic [SLOT_W-1:0] mem_ra, mem_wa;
  slot_rec_t         mem_wd;

  slot_rec_t eval_rec_in, eval_rec_out;
  res_t      eval_res;

  logic [CNT_W-1:0]  tick_idx_q;
  logic              tick_pend_q;
  logic [SLOT_W-1:0] tick_wa_q;
  logic              any_q, any_d;
  logic [31:0]       exp_diff;
  logic              exp_due;
  slot_rec_t         tick_rec;
  logic              tick_last;

  logic out_vld_q;
  res_t out_q, res_d;
  logic out_free, out_load;

  // ---------------------------------------------------------------- input
  assign item_in.mode          = s_axis_tuser[1:0];
  assign item_in.source        = s_axis_tdata[3:0];
  assign item_in.quantity      = s_axis_tdata[7:4];
  assign item_in.enabled       = s_axis_tdata[8];
  assign item_in.low_limit     = s_axis_tdata[40:9];
  assign item_in.high_limit    = s_axis_tdata[72:41];
  assign item_in.hysteresis    = s_axis_tdata[103:73];
  assign item_in.reading_valid = s_axis_tdata[104];
  assign item_in.reading       = s_axis_tdata[136:105];
  assign item_in.from_level    = s_axis_tdata[137];
  assign item_in.to_level      = s_axis_tdata[138];
  assign item_in.now_ms        = s_axis_tdata[170:139];

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q <= item_in;
    end
  end

  // ---------------------------------------------------------------- config
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_ms_q <= HOLD_MS_W'(HOLD_RST_S * MS_PER_S);
    end else if (cfg_valid_i && cfg_ready_o) begin
      hold_ms_q <= HOLD_MS_W'(cfg_data_i * 10'(MS_PER_S));
    end
  end

  // ---------------------------------------------------------------- key match
  assign key = {item_q.source, item_q.quantity};

  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = 0; i < RULE_SLOTS; i++) begin
      hit_vec[i] = slot_used_q[i] && (slot_key_q[i] == key);
    end
    for (int i = RULE_SLOTS - 1; i >= 0; i--) begin
      if (hit_vec[i]) hit_idx = SLOT_W'(i);
      if (!slot_used_q[i]) free_idx = SLOT_W'(i);
    end
  end

  assign hit_any  = |hit_vec;
  assign free_any = ~&slot_used_q;

  always_comb begin
    bnd_d.lo_plus  = {{2{item_q.low_limit[31]}}, item_q.low_limit} + {3'd0, item_q.hysteresis};
    bnd_d.lo_minus = {{2{item_q.low_limit[31]}}, item_q.low_limit} - {3'd0, item_q.hysteresis};
    bnd_d.hi_plus  = {{2{item_q.high_limit[31]}}, item_q.high_limit} + {3'd0, item_q.hysteresis};
    bnd_d.hi_minus = {{2{item_q.high_limit[31]}}, item_q.high_limit} - {3'd0, item_q.hysteresis};
    bnd_d.exp_time = item_q.now_ms + 32'(hold_ms_q);
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_FIND) begin
      slot_q  <= hit_any ? hit_idx : free_idx;
      claim_q <= !hit_any && free_any;
      full_q  <= !hit_any && !free_any;
      bnd_q   <= bnd_d;
    end
  end

  // claiming a slot marks it used at the end of the match cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_used_q <= '0;
    end else if (state_q == S_FIND && !hit_any && free_any) begin
      slot_used_q[free_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_FIND && !hit_any && free_any) begin
      slot_key_q[free_idx] <= key;
    end
  end

  // ---------------------------------------------------------------- slot memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_mem_q[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_q <= slot_mem_q[mem_ra];
    end
  end

  // ---------------------------------------------------------------- evaluate
  assign eval_rec_in = claim_q ? '0 : rd_data_q;

  sare_rule_eval u_eval (
    .item_i (item_q),
    .bnd_i  (bnd_q),
    .rec_i  (eval_rec_in),
    .rec_o  (eval_rec_out),
    .res_o  (eval_res)
  );

  // ---------------------------------------------------------------- tick sweep
  assign exp_diff  = item_q.now_ms - rd_data_q.exp_time;
  assign exp_due   = rd_data_q.exp_pending && !exp_diff[31];
  assign tick_last = (tick_idx_q == CNT_W'(RULE_SLOTS));

  always_comb begin
    tick_rec = rd_data_q;
    if (exp_due) begin
      tick_rec.active      = 1'b0;
      tick_rec.exp_pending = 1'b0;
      tick_rec.exp_time    = '0;
    end
  end

  always_comb begin
    any_d = any_q;
    if (state_q == S_IDLE) begin
      any_d = 1'b0;
    end else if (state_q == S_TICK && tick_pend_q && slot_used_q[tick_wa_q]) begin
      any_d = any_q || tick_rec.active;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_idx_q  <= '0;
      tick_pend_q <= 1'b0;
      any_q       <= 1'b0;
    end else begin
      any_q <= any_d;
      if (state_q == S_TICK) begin
        tick_pend_q <= !tick_last;
        if (!tick_last) tick_idx_q <= tick_idx_q + 1'b1;
      end else begin
        tick_idx_q  <= '0;
        tick_pend_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_TICK) begin
      tick_wa_q <= tick_idx_q[SLOT_W-1:0];
    end
  end

  // ---------------------------------------------------------------- memory ports
  always_comb begin
    mem_re = 1'b0;
    mem_ra = '0;
    mem_we = 1'b0;
    mem_wa = '0;
    mem_wd = eval_rec_out;
    unique case (state_q)
      S_FIND: begin
        mem_re = hit_any || free_any;
        mem_ra = hit_any ? hit_idx : free_idx;
      end
      S_EVAL: begin
        mem_we = !full_q && out_free;
        mem_wa = slot_q;
      end
      S_TICK: begin
        mem_re = !tick_last;
        mem_ra = tick_idx_q[SLOT_W-1:0];
        mem_we = tick_pend_q && slot_used_q[tick_wa_q] && exp_due;
        mem_wa = tick_wa_q;
        mem_wd = tick_rec;
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------- control
  assign out_free = !out_vld_q || m_axis_tready;

  always_comb begin
    state_d  = state_q;
    out_load = 1'b0;
    res_d    = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) state_d = (item_in.mode == MODE_TICK) ? S_TICK : S_FIND;
      end
      S_FIND: state_d = S_EVAL;
      S_EVAL: begin
        if (full_q) begin
          res_d.no_free_slot = 1'b1;
        end else begin
          res_d = eval_res;
        end
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      S_TICK: begin
        if (tick_last && !tick_pend_q) state_d = S_TRES;
      end
      S_TRES: begin
        res_d.any_active = any_q;
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

  // ---------------------------------------------------------------- checks
  `ASSERT_SYNC(a_key_unique, $onehot0(hit_vec), "two slots hold the same key")
  `ASSERT_SYNC(a_claim_used, (state_q == S_FIND && !hit_any && free_any) |=> slot_used_q[slot_q], "claimed slot not marked used")
  `ASSERT_SYNC(a_mem_overlap, (mem_we && mem_re) |-> (mem_wa != mem_ra), "slot read and write collide")
  `ASSERT_SYNC(a_full_quiet, (out_load && res_d.no_free_slot) |-> (!res_d.event_valid && !res_d.rule_active && !mem_we), "full table result carries state")

endmodule
